@@ hdl/pvc_pkg.sv @@
// Shared types, widths and codes for the polyhedron volume and centroid unit.
package pvc_pkg;

   localparam int CRD_W              = 12;
   localparam int MAX_TRIANGLES_DEF  = 256;
   localparam int COORD_BITS_DEF     = 12;
   localparam int FRACTION_BITS_DEF  = 8;

   localparam int DIF_W   = CRD_W + 1;
   localparam int SUM4_W  = CRD_W + 2;
   localparam int CR_W    = 2 * DIF_W + 1;
   localparam int DOT_W   = CR_W + DIF_W + 2;
   localparam int VOL_W   = 51;
   localparam int MOM_W   = 64;
   localparam int MUL_A_W = 41;
   localparam int MUL_B_W = 15;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int CNT_W   = 9;
   localparam int CEN_W   = 20;
   localparam int Q_W     = CEN_W + 1;
   localparam int QCNT_W  = $clog2(Q_W + 1);
   localparam int DEN_SHIFT = Q_W + 1;
   localparam int DIV_W   = VOL_W + DEN_SHIFT;
   localparam int STEP_W  = 4;
   localparam int CALC_LAST = 13;

   typedef logic signed [CRD_W-1:0]   crd_type;
   typedef logic signed [DIF_W-1:0]   dif_type;
   typedef logic signed [SUM4_W-1:0]  sum4_type;
   typedef logic signed [CR_W-1:0]    cr_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic signed [VOL_W-1:0]   vol_type;
   typedef logic signed [MOM_W-1:0]   mom_type;
   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] mul_p_type;
   typedef logic [DIV_W-1:0]          div_type;
   typedef logic [Q_W-1:0]            quo_type;
   typedef logic [QCNT_W-1:0]         qcnt_type;
   typedef logic signed [CEN_W-1:0]   cen_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [STEP_W-1:0]         step_type;

   localparam cen_type CEN_MAX = cen_type'(524287);
   localparam cen_type CEN_MIN = cen_type'(-524288);

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_ZERO     = 2'd1,
      STS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   function automatic crd_type sext_coord(input logic [CRD_W-1:0] v, input int bits);
      logic [CRD_W-1:0] t;
      t = v << (CRD_W - bits);
      return crd_type'($signed(t) >>> (CRD_W - bits));
   endfunction

endpackage

@@ hdl/pvc_mul.sv @@
// Shared signed multiplier with registered product.
module pvc_mul (
   input  logic                clock,
   input  pvc_pkg::mul_a_type  op_a,
   input  pvc_pkg::mul_b_type  op_b,
   output pvc_pkg::mul_p_type  prod
);

   pvc_pkg::mul_p_type prod_ff;
   pvc_pkg::mul_p_type prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hdl/pvc_div.sv @@
// Restoring divider producing one quotient bit per cycle.
module pvc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pvc_pkg::div_type  num,
   input  pvc_pkg::div_type  den,
   output logic              done,
   output pvc_pkg::quo_type  quo
);

   pvc_pkg::div_type  rem_ff, rem_in;
   pvc_pkg::div_type  dvs_ff, dvs_in;
   pvc_pkg::quo_type  quo_ff, quo_in;
   pvc_pkg::qcnt_type cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dvs_in  = den;
         quo_in  = '0;
         cnt_in  = pvc_pkg::qcnt_type'(pvc_pkg::Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[pvc_pkg::Q_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[pvc_pkg::Q_W-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pvc_pkg::qcnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ hdl/polyhedron_volume_centroid_unit.sv @@
// Top level: triangle sequencer, accumulators and result register.
// A triangle is accepted only in idle: 14 steps put twelve products through the
// shared multiplier, then a finish state; a triangle past the count limit goes straight to finish.
// The last triangle adds three divisions (21 steps each) on the shared divider,
// skipped for zero volume, then loads the result register, held while the output is full.
// Synchronous reset clears the sums, count, flags and state; no clearing pass.
module polyhedron_volume_centroid_unit #(
   parameter int MAX_TRIANGLES = pvc_pkg::MAX_TRIANGLES_DEF,
   parameter int COORD_BITS    = pvc_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = pvc_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [11:0] req_base_x,
   input  logic signed [11:0] req_base_y,
   input  logic signed [11:0] req_base_z,
   input  logic signed [11:0] req_prev_x,
   input  logic signed [11:0] req_prev_y,
   input  logic signed [11:0] req_prev_z,
   input  logic signed [11:0] req_cur_x,
   input  logic signed [11:0] req_cur_y,
   input  logic signed [11:0] req_cur_z,
   input  logic               req_last_triangle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [50:0] rsp_six_volume,
   output logic signed [19:0] rsp_center_x,
   output logic signed [19:0] rsp_center_y,
   output logic signed [19:0] rsp_center_z,
   output logic [1:0]         rsp_status
);

   pvc_pkg::state_type  state_ff, state_in;
   pvc_pkg::step_type   step_ff, step_in;
   logic [1:0]          axis_ff, axis_in;
   pvc_pkg::crd_type    base_ff [3], base_in [3];
   pvc_pkg::crd_type    prev_ff [3], prev_in [3];
   pvc_pkg::crd_type    cur_ff [3], cur_in [3];
   pvc_pkg::crd_type    ref_ff [3], ref_in [3];
   logic                last_ff, last_in;
   pvc_pkg::cnt_type    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic                await_ff, await_in;
   pvc_pkg::cr_type     cr_ff [3], cr_in [3];
   pvc_pkg::dot_type    d_ff, d_in;
   pvc_pkg::vol_type    vol_ff, vol_in;
   pvc_pkg::mom_type    mom_ff [3], mom_in [3];
   pvc_pkg::cen_type    cen_ff [3], cen_in [3];
   logic                rsp_valid_ff, rsp_valid_in;
   pvc_pkg::vol_type    rsp_vol_ff, rsp_vol_in;
   pvc_pkg::cen_type    rsp_cen_ff [3], rsp_cen_in [3];
   pvc_pkg::status_type rsp_status_ff, rsp_status_in;

   pvc_pkg::dif_type    dif_a [3];
   pvc_pkg::dif_type    dif_e [3];
   pvc_pkg::dif_type    dif_w [3];
   pvc_pkg::sum4_type   sum4 [3];
   pvc_pkg::dot_type    abs_d;
   pvc_pkg::mul_a_type  mul_a;
   pvc_pkg::mul_b_type  mul_b;
   pvc_pkg::mul_p_type  mul_p;

   pvc_pkg::mom_type    mom_sel;
   logic                mom_neg;
   logic [pvc_pkg::MOM_W-1:0] mom_mag;
   logic                vol_neg;
   logic [pvc_pkg::VOL_W-1:0] vol_mag;
   logic                vol_zero;
   pvc_pkg::div_type    div_num;
   pvc_pkg::div_type    div_den;
   logic                div_start;
   logic                div_done;
   pvc_pkg::quo_type    div_quo;
   logic                cen_neg;
   logic                cen_sat;
   pvc_pkg::cen_type    cen_val;
   logic                emit_load;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dif_a[i] = pvc_pkg::dif_type'(cur_ff[i]) - pvc_pkg::dif_type'(base_ff[i]);
         dif_e[i] = pvc_pkg::dif_type'(prev_ff[i]) - pvc_pkg::dif_type'(base_ff[i]);
         dif_w[i] = pvc_pkg::dif_type'(ref_ff[i]) - pvc_pkg::dif_type'(base_ff[i]);
         sum4[i]  = pvc_pkg::sum4_type'(ref_ff[i]) + pvc_pkg::sum4_type'(base_ff[i])
                  + pvc_pkg::sum4_type'(prev_ff[i]) + pvc_pkg::sum4_type'(cur_ff[i]);
      end
      abs_d = d_ff[pvc_pkg::DOT_W-1] ? -d_ff : d_ff;
   end

   always_comb begin
      mom_sel  = mom_ff[axis_ff];
      mom_neg  = mom_sel[pvc_pkg::MOM_W-1];
      mom_mag  = mom_neg ? -mom_sel : mom_sel;
      vol_neg  = vol_ff[pvc_pkg::VOL_W-1];
      vol_mag  = vol_neg ? -vol_ff : vol_ff;
      vol_zero = (vol_ff == '0);
      div_num  = pvc_pkg::div_type'(mom_mag) << FRACTION_BITS;
      div_den  = pvc_pkg::div_type'(vol_mag) << pvc_pkg::DEN_SHIFT;
      cen_neg  = mom_neg ^ vol_neg;
      cen_sat  = div_quo[pvc_pkg::Q_W-1]
               | (!cen_neg & div_quo[pvc_pkg::Q_W-2])
               | (cen_neg & div_quo[pvc_pkg::Q_W-2] & (|div_quo[pvc_pkg::Q_W-3:0]));
      if (cen_sat) begin
         cen_val = cen_neg ? pvc_pkg::CEN_MIN : pvc_pkg::CEN_MAX;
      end else if (cen_neg) begin
         cen_val = -pvc_pkg::cen_type'(div_quo[pvc_pkg::CEN_W-1:0]);
      end else begin
         cen_val = pvc_pkg::cen_type'(div_quo[pvc_pkg::CEN_W-1:0]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      axis_in       = axis_ff;
      base_in       = base_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      ref_in        = ref_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      await_in      = await_ff;
      cr_in         = cr_ff;
      d_in          = d_ff;
      vol_in        = vol_ff;
      mom_in        = mom_ff;
      cen_in        = cen_ff;
      rsp_vol_in    = rsp_vol_ff;
      rsp_cen_in    = rsp_cen_ff;
      rsp_status_in = rsp_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      emit_load     = 1'b0;

      case (state_ff)
         pvc_pkg::ST_IDLE: begin
            if (req_valid) begin
               base_in[0] = pvc_pkg::sext_coord(req_base_x, COORD_BITS);
               base_in[1] = pvc_pkg::sext_coord(req_base_y, COORD_BITS);
               base_in[2] = pvc_pkg::sext_coord(req_base_z, COORD_BITS);
               prev_in[0] = pvc_pkg::sext_coord(req_prev_x, COORD_BITS);
               prev_in[1] = pvc_pkg::sext_coord(req_prev_y, COORD_BITS);
               prev_in[2] = pvc_pkg::sext_coord(req_prev_z, COORD_BITS);
               cur_in[0]  = pvc_pkg::sext_coord(req_cur_x, COORD_BITS);
               cur_in[1]  = pvc_pkg::sext_coord(req_cur_y, COORD_BITS);
               cur_in[2]  = pvc_pkg::sext_coord(req_cur_z, COORD_BITS);
               last_in    = req_last_triangle;
               if (await_ff) begin
                  ref_in[0] = pvc_pkg::sext_coord(req_base_x, COORD_BITS);
                  ref_in[1] = pvc_pkg::sext_coord(req_base_y, COORD_BITS);
                  ref_in[2] = pvc_pkg::sext_coord(req_base_z, COORD_BITS);
                  await_in  = 1'b0;
               end
               if (cnt_ff >= pvc_pkg::cnt_type'(MAX_TRIANGLES)) begin
                  ovf_in   = 1'b1;
                  state_in = pvc_pkg::ST_FINISH;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  step_in  = '0;
                  state_in = pvc_pkg::ST_CALC;
               end
            end
         end

         pvc_pkg::ST_CALC: begin
            case (step_ff)
               4'd0: begin
                  mul_a = pvc_pkg::mul_a_type'(dif_a[1]);
                  mul_b = pvc_pkg::mul_b_type'(dif_e[2]);
               end
               4'd1: begin
                  mul_a = pvc_pkg::mul_a_type'(dif_a[2]);
                  mul_b = pvc_pkg::mul_b_type'(dif_e[1]);
               end
               4'd2: begin
                  mul_a = pvc_pkg::mul_a_type'(dif_a[2]);
                  mul_b = pvc_pkg::mul_b_type'(dif_e[0]);
               end
               4'd3: begin
                  mul_a = pvc_pkg::mul_a_type'(dif_a[0]);
                  mul_b = pvc_pkg::mul_b_type'(dif_e[2]);
               end
               4'd4: begin
                  mul_a = pvc_pkg::mul_a_type'(dif_a[0]);
                  mul_b = pvc_pkg::mul_b_type'(dif_e[1]);
               end
               4'd5: begin
                  mul_a = pvc_pkg::mul_a_type'(dif_a[1]);
                  mul_b = pvc_pkg::mul_b_type'(dif_e[0]);
               end
               4'd6: begin
                  mul_a = pvc_pkg::mul_a_type'(cr_ff[0]);
                  mul_b = pvc_pkg::mul_b_type'(dif_w[0]);
               end
               4'd7: begin
                  mul_a = pvc_pkg::mul_a_type'(cr_ff[1]);
                  mul_b = pvc_pkg::mul_b_type'(dif_w[1]);
               end
               4'd8: begin
                  mul_a = pvc_pkg::mul_a_type'(cr_ff[2]);
                  mul_b = pvc_pkg::mul_b_type'(dif_w[2]);
               end
               4'd10: begin
                  mul_a = pvc_pkg::mul_a_type'(abs_d);
                  mul_b = pvc_pkg::mul_b_type'(sum4[0]);
               end
               4'd11: begin
                  mul_a = pvc_pkg::mul_a_type'(abs_d);
                  mul_b = pvc_pkg::mul_b_type'(sum4[1]);
               end
               4'd12: begin
                  mul_a = pvc_pkg::mul_a_type'(abs_d);
                  mul_b = pvc_pkg::mul_b_type'(sum4[2]);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase

            case (step_ff)
               4'd1:  cr_in[0] = pvc_pkg::cr_type'(mul_p);
               4'd2:  cr_in[0] = cr_ff[0] - pvc_pkg::cr_type'(mul_p);
               4'd3:  cr_in[1] = pvc_pkg::cr_type'(mul_p);
               4'd4:  cr_in[1] = cr_ff[1] - pvc_pkg::cr_type'(mul_p);
               4'd5:  cr_in[2] = pvc_pkg::cr_type'(mul_p);
               4'd6:  cr_in[2] = cr_ff[2] - pvc_pkg::cr_type'(mul_p);
               4'd7:  d_in = pvc_pkg::dot_type'(mul_p);
               4'd8:  d_in = d_ff + pvc_pkg::dot_type'(mul_p);
               4'd9:  d_in = d_ff + pvc_pkg::dot_type'(mul_p);
               4'd10: vol_in = vol_ff - pvc_pkg::vol_type'(d_ff);
               4'd11: mom_in[0] = mom_ff[0] + pvc_pkg::mom_type'(mul_p);
               4'd12: mom_in[1] = mom_ff[1] + pvc_pkg::mom_type'(mul_p);
               4'd13: mom_in[2] = mom_ff[2] + pvc_pkg::mom_type'(mul_p);
               default: begin
               end
            endcase

            step_in = step_ff + 1'b1;
            if (step_ff == pvc_pkg::step_type'(pvc_pkg::CALC_LAST)) begin
               state_in = pvc_pkg::ST_FINISH;
            end
         end

         pvc_pkg::ST_FINISH: begin
            if (!last_ff) begin
               state_in = pvc_pkg::ST_IDLE;
            end else if (vol_zero) begin
               state_in = pvc_pkg::ST_EMIT;
            end else begin
               axis_in  = '0;
               state_in = pvc_pkg::ST_DIV_GO;
            end
         end

         pvc_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = pvc_pkg::ST_DIV_WAIT;
         end

         pvc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               cen_in[axis_ff] = cen_val;
               if (axis_ff == 2'd2) begin
                  state_in = pvc_pkg::ST_EMIT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = pvc_pkg::ST_DIV_GO;
               end
            end
         end

         pvc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit_load  = 1'b1;
               rsp_vol_in = vol_ff;
               for (int i = 0; i < 3; i++) begin
                  rsp_cen_in[i] = vol_zero ? '0 : cen_ff[i];
                  mom_in[i]     = '0;
                  ref_in[i]     = '0;
               end
               if (ovf_ff) begin
                  rsp_status_in = pvc_pkg::STS_OVERFLOW;
               end else if (vol_zero) begin
                  rsp_status_in = pvc_pkg::STS_ZERO;
               end else begin
                  rsp_status_in = pvc_pkg::STS_OK;
               end
               vol_in   = '0;
               cnt_in   = '0;
               ovf_in   = 1'b0;
               await_in = 1'b1;
               state_in = pvc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pvc_pkg::ST_IDLE;
         step_ff      <= '0;
         axis_ff      <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         await_ff     <= 1'b1;
         vol_ff       <= '0;
         mom_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         await_ff     <= await_in;
         vol_ff       <= vol_in;
         mom_ff       <= mom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      ref_ff        <= ref_in;
      last_ff       <= last_in;
      cr_ff         <= cr_in;
      d_ff          <= d_in;
      cen_ff        <= cen_in;
      rsp_vol_ff    <= rsp_vol_in;
      rsp_cen_ff    <= rsp_cen_in;
      rsp_status_ff <= rsp_status_in;
   end

   pvc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   pvc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_ready      = (state_ff == pvc_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_six_volume = rsp_vol_ff;
   assign rsp_center_x   = rsp_cen_ff[0];
   assign rsp_center_y   = rsp_cen_ff[1];
   assign rsp_center_z   = rsp_cen_ff[2];
   assign rsp_status     = rsp_status_ff;

endmodule

@@ bench/pvc_solid_check.sv @@
`timescale 1ns / 1ps
// Checker: models the volume/centroid accumulator and compares every result beat.
module pvc_solid_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  pvc_pkg::crd_type     req_base_x,
   input  pvc_pkg::crd_type     req_base_y,
   input  pvc_pkg::crd_type     req_base_z,
   input  pvc_pkg::crd_type     req_prev_x,
   input  pvc_pkg::crd_type     req_prev_y,
   input  pvc_pkg::crd_type     req_prev_z,
   input  pvc_pkg::crd_type     req_cur_x,
   input  pvc_pkg::crd_type     req_cur_y,
   input  pvc_pkg::crd_type     req_cur_z,
   input  logic                 req_last_triangle,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pvc_pkg::vol_type     rsp_six_volume,
   input  pvc_pkg::cen_type     rsp_center_x,
   input  pvc_pkg::cen_type     rsp_center_y,
   input  pvc_pkg::cen_type     rsp_center_z,
   input  logic [1:0]           rsp_status,
   output int                   mismatches,
   output int                   outstanding
);

   typedef struct packed {
      pvc_pkg::vol_type    six_vol;
      pvc_pkg::cen_type    cx;
      pvc_pkg::cen_type    cy;
      pvc_pkg::cen_type    cz;
      pvc_pkg::status_type sts;
   } solid_type;

   solid_type solids_due[$];
   longint    anchor[3];
   longint    vol6_acc;
   longint    moment_acc[3];
   int        body_tris;
   bit        too_many;
   bit        new_body;

   // moment / (4 * six_volume) with the fraction bits, toward zero, clamped
   function automatic pvc_pkg::cen_type centroid_of(input longint moment, input longint vol6);
      bit [63:0] mmag, den, q0, rem, mag;
      bit        mneg, dneg, neg;
      mneg = moment < 0;
      dneg = vol6 < 0;
      mmag = mneg ? -moment : moment;
      den  = (dneg ? -vol6 : vol6) * 4;
      q0   = mmag / den;
      rem  = mmag % den;
      neg  = mneg ^ dneg;
      if (q0 >= (64'd1 << pvc_pkg::CEN_W))
         return neg ? pvc_pkg::CEN_MIN : pvc_pkg::CEN_MAX;
      mag = (q0 << pvc_pkg::FRACTION_BITS_DEF) + ((rem << pvc_pkg::FRACTION_BITS_DEF) / den);
      if (neg)
         return (mag > 64'd524288) ? pvc_pkg::CEN_MIN : pvc_pkg::cen_type'(-longint'(mag));
      return (mag > 64'd524287) ? pvc_pkg::CEN_MAX : pvc_pkg::cen_type'(mag);
   endfunction

   always @(posedge clock) begin : track
      longint    bq[3], pq[3], cq[3], ed_a[3], ed_e[3], wr[3], cr[3];
      longint    dv, av, sv;
      solid_type want;
      int        faults;
      faults = 0;
      if (reset) begin
         solids_due.delete();
         for (int i = 0; i < 3; i++) begin
            anchor[i] = 0;
            moment_acc[i] = 0;
         end
         vol6_acc = 0;
         body_tris = 0;
         too_many = 0;
         new_body = 1;
         mismatches <= 0;
         outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            bq[0] = req_base_x; bq[1] = req_base_y; bq[2] = req_base_z;
            pq[0] = req_prev_x; pq[1] = req_prev_y; pq[2] = req_prev_z;
            cq[0] = req_cur_x;  cq[1] = req_cur_y;  cq[2] = req_cur_z;
            if (new_body) begin
               for (int i = 0; i < 3; i++)
                  anchor[i] = bq[i];
               new_body = 0;
            end
            if (body_tris >= pvc_pkg::MAX_TRIANGLES_DEF) begin
               too_many = 1;
            end else begin
               body_tris++;
               for (int i = 0; i < 3; i++) begin
                  ed_a[i] = cq[i] - bq[i];
                  ed_e[i] = pq[i] - bq[i];
                  wr[i]   = anchor[i] - bq[i];
               end
               cr[0] = ed_a[1] * ed_e[2] - ed_a[2] * ed_e[1];
               cr[1] = ed_a[2] * ed_e[0] - ed_a[0] * ed_e[2];
               cr[2] = ed_a[0] * ed_e[1] - ed_a[1] * ed_e[0];
               dv = cr[0] * wr[0] + cr[1] * wr[1] + cr[2] * wr[2];
               vol6_acc -= dv;
               av = (dv < 0) ? -dv : dv;
               for (int i = 0; i < 3; i++) begin
                  sv = anchor[i] + bq[i] + pq[i] + cq[i];
                  moment_acc[i] += av * sv;
               end
            end
            if (req_last_triangle) begin
               want.six_vol = pvc_pkg::vol_type'(vol6_acc);
               if (vol6_acc == 0) begin
                  want.cx = '0;
                  want.cy = '0;
                  want.cz = '0;
                  want.sts = pvc_pkg::STS_ZERO;
               end else begin
                  want.cx = centroid_of(moment_acc[0], vol6_acc);
                  want.cy = centroid_of(moment_acc[1], vol6_acc);
                  want.cz = centroid_of(moment_acc[2], vol6_acc);
                  want.sts = pvc_pkg::STS_OK;
               end
               if (too_many)
                  want.sts = pvc_pkg::STS_OVERFLOW;
               solids_due = {solids_due, want};
               for (int i = 0; i < 3; i++) begin
                  anchor[i] = 0;
                  moment_acc[i] = 0;
               end
               vol6_acc = 0;
               body_tris = 0;
               too_many = 0;
               new_body = 1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (solids_due.size() == 0) begin
               $display("%0t unexpected result beat: expected none, actual six_volume %0d",
                        $time, rsp_six_volume);
               faults++;
            end else begin
               want = solids_due.pop_front();
               if (rsp_six_volume !== want.six_vol) begin
                  $display("%0t six_volume expected %0d actual %0d",
                           $time, want.six_vol, rsp_six_volume);
                  faults++;
               end
               if (rsp_center_x !== want.cx) begin
                  $display("%0t center_x expected %0d actual %0d", $time, want.cx, rsp_center_x);
                  faults++;
               end
               if (rsp_center_y !== want.cy) begin
                  $display("%0t center_y expected %0d actual %0d", $time, want.cy, rsp_center_y);
                  faults++;
               end
               if (rsp_center_z !== want.cz) begin
                  $display("%0t center_z expected %0d actual %0d", $time, want.cz, rsp_center_z);
                  faults++;
               end
               if (rsp_status !== want.sts) begin
                  $display("%0t status expected %0d actual %0d", $time, want.sts, rsp_status);
                  faults++;
               end
            end
         end
         mismatches <= mismatches + faults;
         outstanding <= solids_due.size();
      end
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Bench top: feeds fan-split polyhedra to the unit, paces the result side, gives the verdict.
module tb_top;

   localparam pvc_pkg::crd_type LO = pvc_pkg::crd_type'(-2048);
   localparam pvc_pkg::crd_type HI = pvc_pkg::crd_type'(2047);

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   pvc_pkg::crd_type req_base_x = '0, req_base_y = '0, req_base_z = '0;
   pvc_pkg::crd_type req_prev_x = '0, req_prev_y = '0, req_prev_z = '0;
   pvc_pkg::crd_type req_cur_x = '0, req_cur_y = '0, req_cur_z = '0;
   logic             req_last_triangle = 0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   pvc_pkg::vol_type rsp_six_volume;
   pvc_pkg::cen_type rsp_center_x, rsp_center_y, rsp_center_z;
   logic [1:0]       rsp_status;

   int               mismatches;
   int               outstanding;
   int               sent = 0;
   int               hold_left = 0;
   logic             quiet = 0;
   logic             stall_ask = 0;
   logic             stall_done = 0;
   logic             flip = 0;
   pvc_pkg::crd_type vx[16], vy[16], vz[16];

   always #1 clock = ~clock;

   polyhedron_volume_centroid_unit DUT (.*);

   pvc_solid_check u_check (.*);

   // result side: random stalls, one long hold-off, a quiet stretch
   always @(posedge clock) begin
      if (stall_ask && !stall_done) begin
         stall_done <= 1;
         hold_left <= 400;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 30);
      end
   end

   function automatic pvc_pkg::crd_type pick_coord(input int ctr, input int spread);
      int v;
      if (spread == 0)
         return pvc_pkg::crd_type'($urandom_range(0, 4095));
      v = ctr + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 2047)
         v = 2047;
      if (v < -2048)
         v = -2048;
      return pvc_pkg::crd_type'(v);
   endfunction

   task automatic fill_vertices(input int n);
      int cx, cy, cz, sp;
      sp = ($urandom_range(0, 99) < 30) ? 0 : int'($urandom_range(1, 400));
      cx = int'($urandom_range(0, 3000)) - 1500;
      cy = int'($urandom_range(0, 3000)) - 1500;
      cz = int'($urandom_range(0, 3000)) - 1500;
      for (int i = 0; i < n; i++) begin
         vx[i] = pick_coord(cx, sp);
         vy[i] = pick_coord(cy, sp);
         vz[i] = pick_coord(cz, sp);
      end
      flip = 1'($urandom_range(0, 1));
   endtask

   task automatic send_tri(input pvc_pkg::crd_type bx, by, bz, px, py, pz, cx, cy, cz,
                           input logic last);
      if (!quiet && $urandom_range(0, 99) < 30) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_base_x <= bx; req_base_y <= by; req_base_z <= bz;
      req_prev_x <= px; req_prev_y <= py; req_prev_z <= pz;
      req_cur_x <= cx;  req_cur_y <= cy;  req_cur_z <= cz;
      req_last_triangle <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent++;
   endtask

   task automatic send_face(input int b, input int p, input int c, input logic last);
      if (flip)
         send_tri(vx[b], vy[b], vz[b], vx[c], vy[c], vz[c], vx[p], vy[p], vz[p], last);
      else
         send_tri(vx[b], vy[b], vz[b], vx[p], vy[p], vz[p], vx[c], vy[c], vz[c], last);
   endtask

   // closed when faces is 4; fewer faces make a broken body
   task automatic send_tetra(input int faces);
      for (int f = 0; f < faces; f++) begin
         case (f)
            0: send_face(0, 1, 2, f == faces - 1);
            1: send_face(0, 3, 1, f == faces - 1);
            2: send_face(0, 2, 3, f == faces - 1);
            default: send_face(1, 3, 2, f == faces - 1);
         endcase
      end
   endtask

   // apex at 0, ring 1..k; the ring face goes in as one fan
   task automatic send_pyramid(input int k);
      for (int i = 1; i <= k - 2; i++)
         send_face(1, i + 2, i + 1, 0);
      for (int i = 1; i <= k; i++)
         send_face(0, i, (i % k) + 1, i == k);
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) begin
         fill_vertices(3);
         send_face(0, 1, 2, i == n - 1);
      end
   endtask

   initial begin
      bit big_a, big_b;
      int pick, k;
      big_a = 0;
      big_b = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // lone triangle at the corners of the grid
      send_tri(LO, LO, LO, HI, HI, HI, HI, LO, HI, 1);

      // corner tetrahedron in both orientations
      vx[0] = LO; vy[0] = LO; vz[0] = LO;
      vx[1] = HI; vy[1] = LO; vz[1] = LO;
      vx[2] = LO; vy[2] = HI; vz[2] = LO;
      vx[3] = LO; vy[3] = LO; vz[3] = HI;
      flip = 0;
      send_tetra(4);
      flip = 1;
      send_tetra(4);

      // near cancellation: tiny volume, large moment, centroid clamps both ways
      send_tri(0, 0, 0, 5, 6, 7, 9, 1, 3, 0);
      send_tri(0, 0, -1, 0, 2000, -1, 2000, 0, -1, 0);
      send_tri(0, 0, -1, 2000, 0, -1, 0, 1999, -1, 1);

      // every base on the reference point
      send_tri(100, -50, 7, 300, 20, -9, -4, 5, 6, 0);
      send_tri(100, -50, 7, -4, 5, 6, HI, LO, 0, 1);

      while (sent < 1700) begin
         quiet <= (sent >= 700 && sent < 1000);
         if (sent >= 300 && !stall_ask)
            stall_ask <= 1;
         if (sent >= 400 && !big_a) begin
            big_a = 1;
            send_noise(pvc_pkg::MAX_TRIANGLES_DEF);
         end else if (sent >= 1200 && !big_b) begin
            big_b = 1;
            send_noise(pvc_pkg::MAX_TRIANGLES_DEF + int'($urandom_range(1, 4)));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               fill_vertices(4);
               send_tetra(4);
            end else if (pick < 75) begin
               k = $urandom_range(3, 8);
               fill_vertices(k + 1);
               send_pyramid(k);
            end else if (pick < 90) begin
               send_noise($urandom_range(1, 12));
            end else begin
               fill_vertices(4);
               send_tetra($urandom_range(1, 3));
            end
         end
      end
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
